/* rtl/lcr_pkg.sv */
// ----------------------------------------------------------------------------
// lcr_pkg
// Types, character codes and name tables for the line command recognizer.
// ----------------------------------------------------------------------------
package lcr_pkg;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [3:0] VERSION_LEN = 4'd7;
  localparam logic [3:0] DFU_LEN     = 4'd3;
  localparam logic [3:0] FIRST_LEN_MAX = 4'd15;
  localparam logic [5:0] TOKENS_MAX  = 6'd63;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_VERSION = 2'd1,
    CMD_DFU     = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [5:0] line_length;
    logic       between_tokens;
    logic [5:0] tokens_seen;
    logic       text_ended;
    logic [3:0] first_len;
    logic       match_version;
    logic       match_dfu;
  } line_state_t;

  localparam line_state_t LINE_RESET = '{
    line_length:    6'd0,
    between_tokens: 1'b1,
    tokens_seen:    6'd0,
    text_ended:     1'b0,
    first_len:      4'd0,
    match_version:  1'b1,
    match_dfu:      1'b1
  };

  typedef struct packed {
    logic       valid;
    cmd_e       command;
    logic [5:0] token_count;
  } line_result_t;

  function automatic logic [7:0] version_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h76; // v
      4'd1:    c = 8'h65; // e
      4'd2:    c = 8'h72; // r
      4'd3:    c = 8'h73; // s
      4'd4:    c = 8'h69; // i
      4'd5:    c = 8'h6F; // o
      4'd6:    c = 8'h6E; // n
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] dfu_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h64; // d
      4'd1:    c = 8'h66; // f
      4'd2:    c = 8'h75; // u
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

/* rtl/lcr_line_step.sv */
// ----------------------------------------------------------------------------
// lcr_line_step
// Next line state and end-of-line result for one received character.
// ----------------------------------------------------------------------------
module lcr_line_step (
  input  lcr_pkg::line_state_t  state_i,
  input  logic [7:0]            ch_i,
  input  logic                  line_full_i,
  output lcr_pkg::line_state_t  state_o,
  output lcr_pkg::line_result_t result_o
);
  import lcr_pkg::*;

  logic       is_ws;
  logic       is_comma;
  logic       do_match;
  logic [7:0] low_ch;

  assign is_ws    = (ch_i == CH_SPACE) || (ch_i == CH_TAB);
  assign is_comma = (ch_i == CH_COMMA);
  assign low_ch   = (ch_i inside {[CH_UPPER_A:CH_UPPER_Z]}) ? ch_i + CASE_OFFSET : ch_i;

  always_comb begin
    state_o              = state_i;
    result_o.valid       = 1'b0;
    result_o.command     = CMD_NONE;
    result_o.token_count = state_i.tokens_seen;
    do_match             = 1'b0;

    if ((ch_i == CH_CR) || (ch_i == CH_LF)) begin
      // an empty line leaves everything as it is
      if (state_i.line_length != 6'd0) begin
        result_o.valid = 1'b1;
        if (state_i.tokens_seen == 6'd0) begin
          result_o.command = CMD_NONE;
        end else if (state_i.match_version && (state_i.first_len == VERSION_LEN)) begin
          result_o.command = CMD_VERSION;
        end else if (state_i.match_dfu && (state_i.first_len == DFU_LEN)) begin
          result_o.command = CMD_DFU;
        end else begin
          result_o.command = CMD_UNKNOWN;
        end
        state_o = LINE_RESET;
      end
    end else if (!line_full_i) begin
      state_o.line_length = state_i.line_length + 6'd1;
      if (!state_i.text_ended) begin
        if (ch_i == CH_NUL) begin
          state_o.text_ended = 1'b1;
        end else if (state_i.between_tokens) begin
          if (!is_ws) begin
            if (state_i.tokens_seen != TOKENS_MAX) begin
              state_o.tokens_seen = state_i.tokens_seen + 6'd1;
            end
            // a comma here closes an empty token
            if (!is_comma) begin
              state_o.between_tokens = 1'b0;
              do_match = (state_i.tokens_seen == 6'd0);
            end
          end
        end else begin
          if (is_ws || is_comma) begin
            state_o.between_tokens = 1'b1;
          end else begin
            do_match = (state_i.tokens_seen == 6'd1);
          end
        end
      end
    end

    if (do_match) begin
      if ((state_i.first_len >= VERSION_LEN) || (version_char(state_i.first_len) != low_ch)) begin
        state_o.match_version = 1'b0;
      end
      if ((state_i.first_len >= DFU_LEN) || (dfu_char(state_i.first_len) != low_ch)) begin
        state_o.match_dfu = 1'b0;
      end
      if (state_i.first_len != FIRST_LEN_MAX) begin
        state_o.first_len = state_i.first_len + 4'd1;
      end
    end
  end

endmodule

/* rtl/line_command_recognizer.sv */
// ----------------------------------------------------------------------------
// line_command_recognizer
// Tokenizes received characters and reports the command of each line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one character word per cycle on ch_i with in_valid_i;
//   it is taken at a clock edge where in_valid_i is high and in_stall_o low.
//   Output channel: one word per non-empty line, given when CR or LF
//   arrives, with command_o and token_count_o; taken where out_valid_o is
//   high and out_stall_i low.
//   Each result is registered in the output register, or in the skid register.
//   Throughput: one character per cycle while in_stall_o is low; the line state
//   update is a single compare-and-count step between the line state register
//   and the output register.
//   When the receiver stalls, a second result is held in a skid register;
//   in_stall_o rises only while that skid register is occupied.
//   Reset clears the line state (no tokens, nothing kept) and empties the
//   output and skid registers.
//   At most LINE_CAPACITY-1 characters of a line are kept; later ones up to
//   the line end are dropped.
// ----------------------------------------------------------------------------
module line_command_recognizer #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] command_o,
  output logic [5:0] token_count_o
);
  import lcr_pkg::*;

  localparam logic [5:0] KEEP_MAX = 6'(LINE_CAPACITY - 1);

  line_state_t  state_q, state_d, state_next;
  line_result_t step_res;
  logic         in_fire;
  logic         out_fire;

  logic       out_valid_q, out_valid_d;
  cmd_e       out_cmd_q, out_cmd_d;
  logic [5:0] out_count_q, out_count_d;
  logic       skid_valid_q, skid_valid_d;
  cmd_e       skid_cmd_q, skid_cmd_d;
  logic [5:0] skid_count_q, skid_count_d;

  lcr_line_step u_step (
    .state_i     (state_q),
    .ch_i        (ch_i),
    .line_full_i (state_q.line_length >= KEEP_MAX),
    .state_o     (state_next),
    .result_o    (step_res)
  );

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;

  always_comb begin
    state_d      = in_fire ? state_next : state_q;
    out_valid_d  = out_valid_q;
    out_cmd_d    = out_cmd_q;
    out_count_d  = out_count_q;
    skid_valid_d = skid_valid_q;
    skid_cmd_d   = skid_cmd_q;
    skid_count_d = skid_count_q;

    if (skid_valid_q) begin
      // input is stalled, so only the skid word can move
      if (out_fire) begin
        out_valid_d  = 1'b1;
        out_cmd_d    = skid_cmd_q;
        out_count_d  = skid_count_q;
        skid_valid_d = 1'b0;
      end
    end else begin
      if (!out_valid_q || out_fire) begin
        out_valid_d = in_fire && step_res.valid;
        out_cmd_d   = step_res.command;
        out_count_d = step_res.token_count;
      end else if (in_fire && step_res.valid) begin
        skid_valid_d = 1'b1;
        skid_cmd_d   = step_res.command;
        skid_count_d = step_res.token_count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= LINE_RESET;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cmd_q    <= out_cmd_d;
    out_count_q  <= out_count_d;
    skid_cmd_q   <= skid_cmd_d;
    skid_count_q <= skid_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign command_o     = out_cmd_q;
  assign token_count_o = out_count_q;

endmodule
